// ----- src/mm3b_pkg.sv -----
// Package: shared types and constants for the streaming MurmurHash3 bucket hash.
`default_nettype none

package mm3b_pkg;

	localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
	localparam logic [31:0] MIX_C2  = 32'h1b873593;
	localparam logic [31:0] MIX_ADD = 32'he6546b64;
	localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
	localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	localparam logic [2:0] FULL_BYTES = 3'd4;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} mm3b_in_t;

	typedef struct packed {
		logic [31:0] hash_value;
		logic [9:0]  bucket_index;
	} mm3b_out_t;

	// Mixing rule picked by the front end.
	typedef enum logic {
		CLS_TAIL,
		CLS_BODY
	} mm3b_cls_t;

	// One scrambled key word as it waits in the queue.
	typedef struct packed {
		logic [31:0] k;
		mm3b_cls_t   cls;
		logic [2:0]  nbytes;
		logic        last;
	} mm3b_word_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		ST_MIX,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_DIV,
		ST_REM,
		ST_OUT
	} mm3b_state_t;

endpackage

`default_nettype wire

// ----- src/mm3b_front.sv -----
// Front end: accept key words, classify and mask them, and scramble them in three stages.
`default_nettype none

module mm3b_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  word_valid,
	output logic                       word_stall,
	input  wire mm3b_pkg::mm3b_in_t    word,
	output logic                       push,
	output mm3b_pkg::mm3b_word_t       push_data,
	input  wire logic                  q_full
);
	import mm3b_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic [31:0] word_s1, k_s2, k_s3;
	mm3b_cls_t   cls_s1, cls_s2, cls_s3;
	logic [2:0]  nb_s1, nb_s2, nb_s3;
	logic        last_s1, last_s2, last_s3;

	logic        freeze;
	logic        accept;
	logic [2:0]  nbytes;
	logic [31:0] mask;
	logic [31:0] k_rot;

	// Hold the whole pipe while the oldest item cannot enter the queue.
	assign freeze     = v_s3 && q_full;
	assign word_stall = freeze;
	assign accept     = word_valid && !freeze;
	assign push       = v_s3 && !q_full;

	always_comb begin
		if (!word.last_word) begin
			nbytes = FULL_BYTES;
		end else if (word.valid_bytes > FULL_BYTES) begin
			nbytes = FULL_BYTES;
		end else begin
			nbytes = word.valid_bytes;
		end
		case (nbytes)
			3'd0:    mask = 32'h0000_0000;
			3'd1:    mask = 32'h0000_00ff;
			3'd2:    mask = 32'h0000_ffff;
			3'd3:    mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
	end

	assign k_rot = {k_s2[16:0], k_s2[31:17]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (!freeze) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!freeze) begin
			word_s1 <= word.data_word & mask;
			cls_s1  <= (nbytes == FULL_BYTES) ? CLS_BODY : CLS_TAIL;
			nb_s1   <= nbytes;
			last_s1 <= word.last_word;

			k_s2    <= word_s1 * MIX_C1;
			cls_s2  <= cls_s1;
			nb_s2   <= nb_s1;
			last_s2 <= last_s1;

			k_s3    <= k_rot * MIX_C2;
			cls_s3  <= cls_s2;
			nb_s3   <= nb_s2;
			last_s3 <= last_s2;
		end
	end

	assign push_data = '{k: k_s3, cls: cls_s3, nbytes: nb_s3, last: last_s3};

endmodule

`default_nettype wire

// ----- src/mm3b_queue.sv -----
// Queue: short first-in first-out buffer of scrambled words between front and back.
`default_nettype none

module mm3b_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire mm3b_pkg::mm3b_word_t  push_data,
	output logic                       full,
	input  wire logic                  pop,
	output mm3b_pkg::mm3b_word_t       head,
	output logic                       empty
);
	import mm3b_pkg::*;

	mm3b_word_t         slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- src/mm3b_back.sv -----
// Back end: running hash update, length fold, finalizer, bucket remainder and result register.
`default_nettype none

module mm3b_back #(
	parameter int unsigned TABLE_BUCKETS = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [31:0]           seed,
	input  wire mm3b_pkg::mm3b_word_t  head,
	input  wire logic                  empty,
	output logic                       pop,
	output logic                       hash_valid,
	input  wire logic                  hash_stall,
	output mm3b_pkg::mm3b_out_t        hash
);
	import mm3b_pkg::*;

	localparam int unsigned RW = $clog2(TABLE_BUCKETS) + 1;
	localparam int unsigned TW = RW + 1;
	localparam logic [TW-1:0] NB = TW'(TABLE_BUCKETS);
	localparam logic [31:0] NB32 = 32'(TABLE_BUCKETS);
	// floor((2^32 - 1) / N): the quotient estimate comes out exact or one short
	localparam logic [31:0] RECIP = 32'(64'h0000_0000_ffff_ffff / 64'(TABLE_BUCKETS));

	mm3b_state_t state_q, state_d;
	logic [31:0] h_q, cnt_q;
	logic        open_q;
	logic [31:0] quo_q;
	logic [RW-1:0] rem_q;
	logic        out_valid_q;
	mm3b_out_t   out_q;

	logic [31:0] h_base, cnt_base, hx, hr, h_mix, cnt_new;
	logic [31:0] f1, f2, f3;
	logic [63:0] prod;
	logic [31:0] back_mul, r_full;
	logic [TW-1:0] rem_wide;
	logic [RW-1:0] rem_next;
	logic [RW+9:0] rem_ext;
	logic        out_load;

	// Datapath terms
	always_comb begin
		h_base   = open_q ? h_q : seed;
		cnt_base = open_q ? cnt_q : 32'd0;
		hx       = h_base ^ head.k;
		hr       = {hx[18:0], hx[31:19]};
		h_mix    = (hr << 2) + hr + MIX_ADD;
		cnt_new  = cnt_base + 32'(head.nbytes);
		f1       = h_q ^ cnt_q;
		f1       = f1 ^ (f1 >> 16);
		f2       = h_q ^ (h_q >> 13);
		f3       = h_q ^ (h_q >> 16);
		// Remainder by reciprocal: estimate the quotient, multiply back, fix up once.
		prod     = {32'd0, h_q} * {32'd0, RECIP};
		back_mul = quo_q * NB32;
		r_full   = h_q - back_mul;
		rem_wide = {1'b0, rem_q};
		if (rem_wide >= NB) begin
			rem_next = RW'(rem_wide - NB);
		end else begin
			rem_next = rem_q;
		end
		rem_ext  = {10'd0, rem_next};
	end

	// Sequencer
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_MIX: begin
				if (!empty) begin
					pop = 1'b1;
					if (head.last) begin
						state_d = ST_FIN1;
					end
				end
			end
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = ST_FIN3;
			ST_FIN3: state_d = ST_DIV;
			ST_DIV:  state_d = ST_REM;
			ST_REM:  state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || !hash_stall) begin
					out_load = 1'b1;
					state_d  = ST_MIX;
				end
			end
			default: state_d = ST_MIX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_MIX;
			h_q         <= '0;
			cnt_q       <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_MIX: begin
					if (pop) begin
						h_q    <= (head.cls == CLS_BODY) ? h_mix : hx;
						cnt_q  <= cnt_new;
						open_q <= !head.last;
					end
				end
				ST_FIN1: h_q <= f1 * FIN_C1;
				ST_FIN2: h_q <= f2 * FIN_C2;
				ST_FIN3: h_q <= f3;
				default: h_q <= h_q;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!hash_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			quo_q <= prod[63:32];
		end
		if (state_q == ST_REM) begin
			rem_q <= r_full[RW-1:0];
		end
		if (out_load) begin
			out_q.hash_value   <= h_q;
			out_q.bucket_index <= rem_ext[9:0];
		end
	end

	assign hash_valid = out_valid_q;
	assign hash       = out_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (TW'(rem_next) < NB))
		else $error("bucket remainder out of range");

endmodule

`default_nettype wire

// ----- src/murmur3_32_bucket_hash.sv -----
// Top level: streaming MurmurHash3 x86_32 with bucket index, seed register and wiring.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+--------------------------------------
//  word in   | word_valid / word_stall  | word: data_word, valid_bytes, last_word
//  hash out  | hash_valid / hash_stall  | hash: hash_value, bucket_index
//  seed cfg  | seed_we                  | seed_wdata
//
// A word passes through the front end registers (mask, multiply, rotate and
// multiply) before it enters a four-entry queue.
// The back end mixes one queued word per cycle while in ST_MIX with the queue not
// empty; a last word then passes the finalizer states ST_FIN1, ST_FIN2 and ST_FIN3,
// the bucket remainder states ST_DIV (reciprocal multiply) and ST_REM (multiply back
// and subtract), and ST_OUT, which loads the result register once it is free.
// Reset clears all control state and the seed at once; there is no clearing pass.
// A stalled result sits in its register while the front end keeps accepting
// words until the queue is full and a word waits in the last front end stage; then word_stall rises.
`default_nettype none

module murmur3_32_bucket_hash #(
	parameter int unsigned TABLE_BUCKETS = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 seed_we,
	input  wire logic [31:0]          seed_wdata,
	input  wire logic                 word_valid,
	output logic                      word_stall,
	input  wire mm3b_pkg::mm3b_in_t   word,
	output logic                      hash_valid,
	input  wire logic                 hash_stall,
	output mm3b_pkg::mm3b_out_t       hash
);
	import mm3b_pkg::*;

	logic [31:0] seed_q;
	logic        push, q_full, pop, q_empty;
	mm3b_word_t  push_data, q_head;

	// Capture the seed; the back end loads it at the start of each key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	// Front end: accept, classify and scramble.
	mm3b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	// Decouple the two sides.
	mm3b_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// Back end: advance the running hash, finalize and emit.
	mm3b_back #(
		.TABLE_BUCKETS (TABLE_BUCKETS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (pop),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash       (hash)
	);

endmodule

`default_nettype wire

// ----- sim/murmur3_32_bucket_hash_tb.sv -----
// Testbench: checks the streaming MurmurHash3 bucket hash against a behavioral predictor.
`timescale 1ns / 100ps

module murmur3_32_bucket_hash_tb;

	import mm3b_pkg::*;

	localparam int unsigned BUCKETS     = 1024;
	localparam int unsigned STALL_LIMIT = 2000; // cycles with no word or result moving
	localparam int unsigned DRAIN_WAIT  = 64;   // covers front end, queue and one key end
	localparam int unsigned RAND_PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 317;  // six phases give about 1900 items

	localparam bit [31:0] K_C1   = 32'hcc9e2d51;
	localparam bit [31:0] K_C2   = 32'h1b873593;
	localparam bit [31:0] H_ADD  = 32'he6546b64;
	localparam bit [31:0] FMIX_A = 32'h85ebca6b;
	localparam bit [31:0] FMIX_B = 32'hc2b2ae35;

	// Predicts the hash of each key from the accepted words and checks results in order.
	class murmur_tracker;
		bit [31:0]  seed_reg;
		bit [31:0]  run_hash;
		bit [31:0]  byte_count;
		bit         key_open;
		mm3b_out_t  expected_hashes[$];
		int unsigned mismatches;
		int unsigned results_seen;

		function new();
			seed_reg     = '0;
			run_hash     = '0;
			byte_count   = '0;
			key_open     = 1'b0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function bit [31:0] rotl(bit [31:0] v, int unsigned s);
			return (v << s) | (v >> (32 - s));
		endfunction

		function bit [31:0] scramble(bit [31:0] k);
			return rotl(k * K_C1, 15) * K_C2;
		endfunction

		function bit [31:0] mix_body(bit [31:0] h, bit [31:0] k);
			return rotl(h ^ scramble(k), 13) * 5 + H_ADD;
		endfunction

		function void load_seed(bit [31:0] v);
			seed_reg = v;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result %0d: %s", $time, results_seen, msg);
		endfunction

		function void absorb_word(mm3b_in_t w);
			bit [31:0] d;
			bit [31:0] mask;
			bit [31:0] h;
			bit [2:0]  n;
			mm3b_out_t r;
			d = w.data_word;
			n = w.valid_bytes;
			// a key opens on its first word and takes the seed current at that point
			if (!key_open) begin
				run_hash   = seed_reg;
				byte_count = '0;
				key_open   = 1'b1;
			end
			// body words always carry four bytes, whatever the byte count says
			if (!w.last_word) begin
				run_hash   = mix_body(run_hash, d);
				byte_count += 32'd4;
				return;
			end
			if (n > 3'd4)
				n = 3'd4;
			if (n == 3'd4) begin
				run_hash = mix_body(run_hash, d);
			end else if (n != 3'd0) begin
				mask     = (32'h1 << (8 * n)) - 32'h1;
				run_hash = run_hash ^ scramble(d & mask);
			end
			byte_count += 32'(n);
			// fold in the length, then fmix
			h = run_hash ^ byte_count;
			h = h ^ (h >> 16);
			h = h * FMIX_A;
			h = h ^ (h >> 13);
			h = h * FMIX_B;
			h = h ^ (h >> 16);
			key_open       = 1'b0;
			r.hash_value   = h;
			r.bucket_index = 10'(h % 32'(BUCKETS));
			expected_hashes.push_back(r);
		endfunction

		function void check_hash(mm3b_out_t got);
			mm3b_out_t want;
			results_seen++;
			if (expected_hashes.size() == 0) begin
				flag($sformatf("no key pending, got hash %h bucket %0d",
					got.hash_value, got.bucket_index));
				return;
			end
			want = expected_hashes.pop_front();
			if (got.hash_value !== want.hash_value)
				flag($sformatf("hash_value expected %h, got %h",
					want.hash_value, got.hash_value));
			if (got.bucket_index !== want.bucket_index)
				flag($sformatf("bucket_index expected %0d, got %0d",
					want.bucket_index, got.bucket_index));
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      seed_we;
	logic [31:0] seed_wdata;
	logic      word_valid;
	logic      word_stall;
	mm3b_in_t  word;
	logic      hash_valid;
	logic      hash_stall;
	mm3b_out_t hash;

	murmur_tracker tracker;
	bit          quiet;        // no idling on either side
	int unsigned sent_items;
	int unsigned calm_left;    // words left in a stretch without sender gaps
	int unsigned idle_cycles;

	murmur3_32_bucket_hash #(
		.TABLE_BUCKETS(BUCKETS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word       (word),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash       (hash)
	);

	always #4 clk = ~clk;

	// Sample both channels and the seed port at the rising edge; the block's
	// outputs only move after the edge, so these reads see the settled values.
	always @(posedge clk) begin
		if (arst_n) begin
			// check before noting the word: a result never belongs to a word taken this edge
			if (hash_valid && !hash_stall)
				tracker.check_hash(hash);
			if (word_valid && !word_stall)
				tracker.absorb_word(word);
			if (seed_we)
				tracker.load_seed(seed_wdata);
			if ((hash_valid && !hash_stall) || (word_valid && !word_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	// Result side: ready runs alternate with random stall bursts; never stalls when quiet.
	initial begin
		int unsigned n;
		hash_stall = 1'b0;
		forever begin
			if (quiet) begin
				hash_stall = 1'b0;
				@(negedge clk);
			end else begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
				hash_stall = 1'b0;
				repeat (n) @(negedge clk);
				n = $urandom_range(1, 5);
				hash_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
		end
	end

	// Present one word at the falling edge and hold it until the block takes it.
	task automatic send_word(bit [31:0] d, bit [2:0] vb, bit last);
		if (!quiet) begin
			if (calm_left > 0) begin
				calm_left--;
			end else if ($urandom_range(0, 19) == 0) begin
				calm_left = $urandom_range(10, 40);
			end else if ($urandom_range(0, 3) == 0) begin
				word_valid = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
		end
		word.data_word   = d;
		word.valid_bytes = vb;
		word.last_word   = last;
		word_valid       = 1'b1;
		do
			@(posedge clk);
		while (word_stall);
		@(negedge clk);
		sent_items++;
	endtask

	// Drop valid, wait for every pending hash, then give the block time to go idle.
	task automatic settle();
		word_valid = 1'b0;
		while (tracker.expected_hashes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_seed(bit [31:0] v);
		seed_wdata = v;
		seed_we    = 1'b1;
		@(negedge clk);
		seed_we    = 1'b0;
	endtask

	// Random data leaning on all-zero, all-one and one-hot words.
	function automatic bit [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h0;
			1:       return 32'hffffffff;
			2:       return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// One well-formed key: mostly short, sometimes long, with a last word of 0 to 7 bytes.
	task automatic send_key();
		int unsigned len;
		int unsigned r;
		bit [2:0]    vb;
		r = $urandom_range(0, 15);
		if (r < 10)
			len = $urandom_range(0, 4);
		else if (r < 15)
			len = $urandom_range(5, 12);
		else
			len = $urandom_range(13, 40);
		repeat (len) send_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
		vb = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
		send_word(pick_word(), vb, 1'b1);
	endtask

	initial begin
		int unsigned goal;
		bit [31:0]   s;
		tracker     = new();
		quiet       = 1'b0;
		sent_items  = 0;
		calm_left   = 0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		seed_we     = 1'b0;
		seed_wdata  = '0;
		word_valid  = 1'b0;
		word        = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed keys under the reset seed.
		send_word(32'h00000000, 3'd0, 1'b1); // empty key: finalization only
		send_word(32'hffffffff, 3'd4, 1'b1);
		send_word(32'hffffffff, 3'd1, 1'b1); // partial tails: upper bytes masked
		send_word(32'hffffffff, 3'd2, 1'b1);
		send_word(32'hffffffff, 3'd3, 1'b1);
		send_word(32'ha5a5a5a5, 3'd5, 1'b1); // byte counts above four saturate
		send_word(32'h5a5a5a5a, 3'd6, 1'b1);
		send_word(32'h00000000, 3'd7, 1'b1);
		send_word(32'h00000000, 3'd0, 1'b0); // byte count ignored on body words
		send_word(32'hffffffff, 3'd7, 1'b0);
		send_word(32'hffffffff, 3'd0, 1'b1); // empty last word after a body
		send_word(32'h12345678, 3'd4, 1'b0); // leave this key open

		// Change the seed while a key is open; the open key keeps the old one.
		settle();
		write_seed(32'hffffffff);
		send_word(32'h80000001, 3'd3, 1'b0);
		send_word(32'hdeadbeef, 3'd2, 1'b1);
		send_word(32'h80000000, 3'd4, 1'b1);
		send_word(32'hff000000, 3'd3, 1'b1); // only the masked byte is set

		// Random keys, one seed per phase; the last phase runs without idling.
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			case (p)
				1:       s = 32'h00000000;
				2:       s = 32'hffffffff;
				4:       s = 32'h00000001;
				default: s = $urandom;
			endcase
			write_seed(s);
			quiet = (p == RAND_PHASES - 1);
			goal  = sent_items + PHASE_ITEMS;
			while (sent_items < goal)
				send_key();
		end

		settle();
		if (tracker.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
src/mm3b_pkg.sv
src/mm3b_front.sv
src/mm3b_queue.sv
src/mm3b_back.sv
src/murmur3_32_bucket_hash.sv
sim/murmur3_32_bucket_hash_tb.sv
